// File: src/sha1_message_digest_top_defines.svh
// ---------------------------------------------------------------------------
// SHA-1 digest assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH

// same-cycle implication
`define SHA1MD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA1MD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sha1md_pkg.sv
// ---------------------------------------------------------------------------
// SHA-1 digest package
// Beat types, control struct and fixed constants of the SHA-1 digest block.
// ---------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned ROUNDS    = 80;
  localparam int unsigned WIN_DEPTH = 16;

  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [3:0][31:0] K_ROUND = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  localparam logic [31:0] PAD_MARK = 32'h8000_0000;

  // 448 / 32: window slot of the high length word
  localparam logic [3:0] LEN_SLOT = 4'(448 / 32);
  localparam logic [3:0] LAST_SLOT = 4'((512 / 32) - 1);

  localparam logic [2:0] FULL_BYTES = 3'd4;
  localparam logic [2:0] LAST_INDEX = 3'd4;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } dig_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic add;
  } core_ctrl_t;

endpackage

// File: src/sha1_message_digest_top.sv
// ---------------------------------------------------------------------------
// SHA-1 message digest. A block's 16th word starts its 80 rounds, then the add into the chaining value.
// Message words are taken back to back while ready; ready drops while a block compresses.
// Last word: padding words per block, each block's rounds and add, then 5 digest beats.
// Reset (rst, synchronous): chaining value to the initial hash, counters cleared.
// ---------------------------------------------------------------------------
`include "sha1_message_digest_top_defines.svh"

module sha1_message_digest_top
  import sha1md_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic msg_valid,
  output logic msg_ready,
  input  msg_t msg,
  output logic dig_valid,
  input  logic dig_ready,
  output dig_t dig
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_ADD, S_OUT} state_t;

  state_t          state;
  logic [3:0]      pos;
  logic [6:0]      rnd;
  logic [63:0]     len;
  logic            marker;
  logic            hi_done;
  logic            len_done;
  logic            finishing;
  logic [2:0]      idx;

  logic            accept;
  logic            dig_fire;
  logic [2:0]      cnt_sat;
  logic [31:0]     merged;
  logic [31:0]     pad_word;
  logic            push_en;
  logic [31:0]     push_data;
  logic            block_full;
  logic [5:0]      len_add;
  logic [31:0]     w;
  logic [4:0][31:0] chain;
  core_ctrl_t      ctrl;

  assign msg_ready = (state == S_IDLE);
  assign accept    = msg_valid && msg_ready;
  assign dig_fire  = dig_valid && dig_ready;

  assign cnt_sat = (msg.byte_count > FULL_BYTES) ? FULL_BYTES : msg.byte_count;

  always_comb begin
    unique case (cnt_sat)
      3'd0:    merged = PAD_MARK;
      3'd1:    merged = {msg.data_word[31:24], 8'h80, 16'h0000};
      3'd2:    merged = {msg.data_word[31:16], 8'h80, 8'h00};
      3'd3:    merged = {msg.data_word[31:8], 8'h80};
      default: merged = msg.data_word;
    endcase
  end

  always_comb begin
    priority if (marker) begin
      pad_word = PAD_MARK;
    end else if (hi_done) begin
      pad_word = len[31:0];
    end else if (pos == LEN_SLOT) begin
      pad_word = len[63:32];
    end else begin
      pad_word = '0;
    end
  end

  assign push_en    = accept || (state == S_PAD);
  assign push_data  = accept ? (msg.last_word ? merged : msg.data_word) : pad_word;
  assign block_full = push_en && (pos == LAST_SLOT);
  assign len_add    = msg.last_word ? {cnt_sat, 3'b000} : 6'd32;

  assign ctrl.init = dig_fire && (idx == LAST_INDEX);
  assign ctrl.load = block_full;
  assign ctrl.step = (state == S_ROUND);
  assign ctrl.add  = (state == S_ADD);

  sha1md_sched u_sched (
    .clk  (clk),
    .shift(push_en || (state == S_ROUND)),
    .ext  (push_en),
    .data (push_data),
    .w    (w)
  );

  sha1md_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .rnd  (rnd),
    .w    (w),
    .chain(chain)
  );

  always_comb begin
    dig.digest_index = idx;
    dig.digest_last  = (idx == LAST_INDEX);
    unique case (idx)
      3'd0:    dig.digest_word = chain[0];
      3'd1:    dig.digest_word = chain[1];
      3'd2:    dig.digest_word = chain[2];
      3'd3:    dig.digest_word = chain[3];
      default: dig.digest_word = chain[4];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      rnd       <= '0;
      len       <= '0;
      marker    <= 1'b0;
      hi_done   <= 1'b0;
      len_done  <= 1'b0;
      finishing <= 1'b0;
      idx       <= '0;
      dig_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            len <= len + 64'(len_add);
            pos <= pos + 4'd1;
            if (msg.last_word) begin
              finishing <= 1'b1;
              marker    <= (cnt_sat == FULL_BYTES);
            end
            if (block_full) begin
              state <= S_ROUND;
              rnd   <= '0;
            end else if (msg.last_word) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pos <= pos + 4'd1;
          priority if (marker) begin
            marker <= 1'b0;
          end else if (hi_done) begin
            len_done <= 1'b1;
          end else if (pos == LEN_SLOT) begin
            hi_done <= 1'b1;
          end
          if (block_full) begin
            state <= S_ROUND;
            rnd   <= '0;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'(ROUNDS - 1)) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (len_done) begin
            state     <= S_OUT;
            dig_valid <= 1'b1;
            idx       <= '0;
          end else if (finishing) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (dig_fire) begin
            if (idx == LAST_INDEX) begin
              dig_valid <= 1'b0;
              state     <= S_IDLE;
              len       <= '0;
              pos       <= '0;
              marker    <= 1'b0;
              hi_done   <= 1'b0;
              len_done  <= 1'b0;
              finishing <= 1'b0;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SHA1MD_ASSERT_IMP(a_no_overlap, msg_ready, !dig_valid, "input taken while digest pending")
  `SHA1MD_ASSERT_IMP(a_rnd_range, (state == S_ROUND), (rnd < 7'(ROUNDS)), "round count overrun")
  `SHA1MD_ASSERT_NXT(a_digest_start, ((state == S_ADD) && len_done),
    (dig_valid && (idx == 3'd0)), "digest not started after final block")
  `SHA1MD_ASSERT_NXT(a_digest_end, (dig_fire && (idx == LAST_INDEX)),
    (msg_ready && (pos == 4'd0) && (len == 64'd0)), "state not cleared after digest")
  `SHA1MD_ASSERT_IMP(a_len_at_wrap, (len_done && (state == S_PAD)), 1'b0,
    "padding continued after length word")

endmodule

// File: src/sha1md_sched.sv
// ---------------------------------------------------------------------------
// SHA-1 message schedule
// 16-word shift window; takes message words, then expands W[t+16] per round.
// ---------------------------------------------------------------------------
module sha1md_sched
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        shift,
  input  logic        ext,
  input  logic [31:0] data,
  output logic [31:0] w
);

  logic [31:0] win [WIN_DEPTH];
  logic [31:0] mix;
  logic [31:0] new_w;

  assign mix   = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign new_w = ext ? data : {mix[30:0], mix[31]};
  assign w     = win[0];

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WIN_DEPTH-1] <= new_w;
    end
  end

endmodule

// File: src/sha1md_core.sv
// ---------------------------------------------------------------------------
// SHA-1 round unit
// Chaining value and a..e registers; one compression round per step.
// ---------------------------------------------------------------------------
module sha1md_core
  import sha1md_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  core_ctrl_t       ctrl,
  input  logic [6:0]       rnd,
  input  logic [31:0]      w,
  output logic [4:0][31:0] chain
);

  logic [31:0] a, b, c, d, e;
  logic [1:0]  stage;
  logic [31:0] f;
  logic [31:0] t;

  always_comb begin
    priority if (rnd < 7'd20) begin
      stage = 2'd0;
    end else if (rnd < 7'd40) begin
      stage = 2'd1;
    end else if (rnd < 7'd60) begin
      stage = 2'd2;
    end else begin
      stage = 2'd3;
    end
  end

  always_comb begin
    unique case (stage)
      2'd0:    f = (b & c) ^ (~b & d);
      2'd2:    f = (b & c) ^ (b & d) ^ (c & d);
      default: f = b ^ c ^ d;
    endcase
  end

  assign t = {a[26:0], a[31:27]} + f + e + K_ROUND[stage] + w;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= H_INIT;
    end else if (ctrl.init) begin
      chain <= H_INIT;
    end else if (ctrl.add) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctrl.step) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

endmodule
